@@ design/klm_pkg.sv @@
// Package for the keyed list multimap: operation and status codes, state codes,
// default sizes and result field widths.
// No dependencies; used by every module of the block but klm_ram.
`timescale 1ns / 1ps

package klm_pkg;

    // Default capacities and field widths
    localparam int MAX_KEYS     = 32;
    localparam int MAX_PER_KEY  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_BITS     = 16;

    localparam int STATUS_W  = 2;
    localparam int PAY_OUT_W = 32;
    localparam int POS_W     = 4;

    // Item queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_INSERT   = 1'b0,
        OP_RETRIEVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_LIST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_EXEC   = 4'b0100,
        S_STREAM = 4'b1000
    } t_state;

endpackage

@@ design/klm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module klm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/klm_front.sv @@
// Front of the keyed list multimap: accepts items, decodes the operation and
// holds them in a short queue for the back. Depends on klm_pkg.
`timescale 1ns / 1ps

module klm_front #(
    parameter int KEY_BITS     = klm_pkg::KEY_BITS,
    parameter int PAYLOAD_BITS = klm_pkg::PAYLOAD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic [KEY_BITS-1:0]     i_node_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    // queue head toward the back
    output logic                    o_q_valid,
    output klm_pkg::t_op            o_q_op,
    output logic [KEY_BITS-1:0]     o_q_key,
    output logic [PAYLOAD_BITS-1:0] o_q_pay,
    input  logic                    i_q_pop
);

    localparam int QD  = klm_pkg::QUEUE_DEPTH;
    localparam int QPW = klm_pkg::QUEUE_PTR_W;
    localparam int QCW = klm_pkg::QUEUE_CNT_W;

    klm_pkg::t_op            r_op  [QD];
    logic [KEY_BITS-1:0]     r_key [QD];
    logic [PAYLOAD_BITS-1:0] r_pay [QD];
    logic [QPW-1:0]          r_wr_ptr;
    logic [QPW-1:0]          r_rd_ptr;
    logic [QCW-1:0]          r_count;
    logic                    push;
    logic                    pop;

    assign o_in_stall = (r_count == QCW'(QD));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_count != '0);

    // Store the decoded item at the tail
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr_ptr]  <= klm_pkg::t_op'(i_func);
            r_key[r_wr_ptr] <= i_node_key;
            r_pay[r_wr_ptr] <= i_payload_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QD - 1)) ? '0 : r_wr_ptr + QPW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QD - 1)) ? '0 : r_rd_ptr + QPW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_op    = r_op[r_rd_ptr];
    assign o_q_key   = r_key[r_rd_ptr];
    assign o_q_pay   = r_pay[r_rd_ptr];

endmodule

@@ design/klm_back.sv @@
// Back of the keyed list multimap: searches the key table, applies inserts,
// streams lists and holds the result register. Depends on klm_pkg, klm_ram.
`timescale 1ns / 1ps

module klm_back #(
    parameter int MAX_KEYS     = klm_pkg::MAX_KEYS,
    parameter int MAX_PER_KEY  = klm_pkg::MAX_PER_KEY,
    parameter int KEY_BITS     = klm_pkg::KEY_BITS,
    parameter int PAYLOAD_BITS = klm_pkg::PAYLOAD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // queue head from the front
    input  logic                            i_q_valid,
    input  klm_pkg::t_op                    i_q_op,
    input  logic [KEY_BITS-1:0]             i_q_key,
    input  logic [PAYLOAD_BITS-1:0]         i_q_pay,
    output logic                            o_q_pop,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output klm_pkg::t_status                o_status,
    output logic [klm_pkg::PAY_OUT_W-1:0]   o_payload_out,
    output logic                            o_payload_valid,
    output logic [klm_pkg::POS_W-1:0]       o_position,
    output logic                            o_last
);

    localparam int IW     = $clog2(MAX_KEYS);
    localparam int CW     = $clog2(MAX_KEYS + 1);
    localparam int LW     = $clog2(MAX_PER_KEY + 1);
    localparam int PDEPTH = MAX_KEYS * MAX_PER_KEY;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int MW     = CW + LW;
    localparam int OW     = klm_pkg::PAY_OUT_W;
    localparam int PW     = klm_pkg::POS_W;

    // Control state
    klm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_keys_used, n_keys_used;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_cidx, n_cidx;
    logic            r_pend, n_pend;
    logic [LW-1:0]   r_pidx, n_pidx;
    logic            r_ovld;

    // Item and lookup context
    klm_pkg::t_op            r_op, n_op;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic                    r_found, n_found;
    logic [IW-1:0]           r_ent, n_ent;
    logic [LW-1:0]           r_len, n_len;
    logic [PAW-1:0]          r_base, n_base;

    // Result register
    klm_pkg::t_status r_ostatus;
    logic [OW-1:0]    r_opay;
    logic             r_opvld;
    logic [PW-1:0]    r_opos;
    logic             r_olast;

    // RAM ports
    logic                    key_we;
    logic [IW-1:0]           key_waddr;
    logic [KEY_BITS-1:0]     key_rdata;
    logic                    len_we;
    logic [IW-1:0]           len_waddr;
    logic [LW-1:0]           len_wdata;
    logic [LW-1:0]           len_rdata;
    logic                    pay_we;
    logic [PAW-1:0]          pay_waddr;
    logic [PAW-1:0]          pay_raddr;
    logic [PAYLOAD_BITS-1:0] pay_rdata;

    // Load strobe and fields for the result register
    logic             ld;
    klm_pkg::t_status ld_status;
    logic [OW-1:0]    ld_pay;
    logic             ld_pvld;
    logic [PW-1:0]    ld_pos;
    logic             ld_last;

    logic          out_free;
    logic          hit;
    logic          miss_end;
    logic [CW-1:0] base_src;
    logic [MW-1:0] base_prod;
    logic [LW-1:0] len_eff;
    logic          strm_last;

    klm_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_KEYS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (key_rdata)
    );

    klm_ram #(.WIDTH(LW), .DEPTH(MAX_KEYS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (len_rdata)
    );

    klm_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(PDEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (r_pay),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    assign out_free = !r_ovld || !i_out_stall;

    // Compare the key read from the registered RAM at the previous index; stop at the last used entry
    assign hit      = (r_state == klm_pkg::S_SEARCH) && r_pend && (key_rdata == r_key);
    assign miss_end = (r_state == klm_pkg::S_SEARCH) && r_pend && !hit
                      && (r_cidx == r_keys_used - CW'(1));

    // Base of the entry's payload rows: found entry or the next free one
    assign base_src  = hit ? r_cidx : r_keys_used;
    assign base_prod = MW'(base_src) * MW'(MAX_PER_KEY);

    assign len_eff   = (r_len > LW'(MAX_PER_KEY)) ? LW'(MAX_PER_KEY) : r_len;
    assign strm_last = (LW'(r_pidx + LW'(1)) == r_len);

    // Write addresses follow the found entry or the next free one
    assign key_waddr = r_keys_used[IW-1:0];
    assign len_waddr = r_found ? r_ent : r_keys_used[IW-1:0];
    assign len_wdata = r_found ? LW'(r_len + LW'(1)) : LW'(1);
    assign pay_waddr = r_base + (r_found ? PAW'(r_len) : '0);
    assign pay_raddr = r_base + PAW'(n_pidx);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_keys_used = r_keys_used;
        n_idx       = r_idx;
        n_cidx      = r_cidx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_op        = r_op;
        n_key       = r_key;
        n_pay       = r_pay;
        n_found     = r_found;
        n_ent       = r_ent;
        n_len       = r_len;
        n_base      = r_base;
        o_q_pop     = 1'b0;
        key_we      = 1'b0;
        len_we      = 1'b0;
        pay_we      = 1'b0;
        ld          = 1'b0;
        ld_status   = klm_pkg::ST_OK;
        ld_pay      = '0;
        ld_pvld     = 1'b0;
        ld_pos      = '0;
        ld_last     = 1'b1;

        unique case (r_state)
            klm_pkg::S_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    n_key   = i_q_key;
                    n_pay   = i_q_pay;
                    if (r_keys_used == '0) begin
                        n_found = 1'b0;
                        n_base  = base_prod[PAW-1:0];
                        n_state = klm_pkg::S_EXEC;
                    end else begin
                        n_state = klm_pkg::S_SEARCH;
                    end
                end
            end

            klm_pkg::S_SEARCH: begin
                n_idx  = r_idx + CW'(1);
                n_cidx = r_idx;
                n_pend = 1'b1;
                if (hit) begin
                    n_found = 1'b1;
                    n_ent   = r_cidx[IW-1:0];
                    n_len   = len_rdata;
                    n_base  = base_prod[PAW-1:0];
                    n_state = klm_pkg::S_EXEC;
                end else if (miss_end) begin
                    n_found = 1'b0;
                    n_base  = base_prod[PAW-1:0];
                    n_state = klm_pkg::S_EXEC;
                end
            end

            klm_pkg::S_EXEC: begin
                // present the first payload address for a stream
                n_pidx = '0;
                if (out_free) begin
                    unique case (r_op)
                        klm_pkg::OP_INSERT: begin
                            ld      = 1'b1;
                            n_state = klm_pkg::S_IDLE;
                            if (r_found) begin
                                if (r_len >= LW'(MAX_PER_KEY)) begin
                                    ld_status = klm_pkg::ST_LIST_FULL;
                                end else begin
                                    len_we = 1'b1;
                                    pay_we = 1'b1;
                                end
                            end else if (r_keys_used >= CW'(MAX_KEYS)) begin
                                ld_status = klm_pkg::ST_TABLE_FULL;
                            end else begin
                                key_we      = 1'b1;
                                len_we      = 1'b1;
                                pay_we      = 1'b1;
                                n_keys_used = r_keys_used + CW'(1);
                            end
                        end
                        klm_pkg::OP_RETRIEVE: begin
                            if (!r_found) begin
                                ld        = 1'b1;
                                ld_status = klm_pkg::ST_NOT_FOUND;
                                n_state   = klm_pkg::S_IDLE;
                            end else if (len_eff == '0) begin
                                ld      = 1'b1;
                                n_state = klm_pkg::S_IDLE;
                            end else begin
                                n_len   = len_eff;
                                n_state = klm_pkg::S_STREAM;
                            end
                        end
                        default: begin
                            n_state = klm_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            klm_pkg::S_STREAM: begin
                // one payload per transfer; read of the next one overlaps
                if (out_free) begin
                    ld      = 1'b1;
                    ld_pay  = OW'(pay_rdata);
                    ld_pvld = 1'b1;
                    ld_pos  = PW'(r_pidx);
                    ld_last = strm_last;
                    n_pidx  = r_pidx + LW'(1);
                    if (strm_last) begin
                        n_state = klm_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = klm_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= klm_pkg::S_IDLE;
            r_keys_used <= '0;
            r_idx       <= '0;
            r_cidx      <= '0;
            r_pend      <= 1'b0;
            r_pidx      <= '0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keys_used <= n_keys_used;
            r_idx       <= n_idx;
            r_cidx      <= n_cidx;
            r_pend      <= n_pend;
            r_pidx      <= n_pidx;
            if (ld) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Item context and result fields
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_found <= n_found;
        r_ent   <= n_ent;
        r_len   <= n_len;
        r_base  <= n_base;
        if (ld) begin
            r_ostatus <= ld_status;
            r_opay    <= ld_pay;
            r_opvld   <= ld_pvld;
            r_opos    <= ld_pos;
            r_olast   <= ld_last;
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_status        = r_ostatus;
    assign o_payload_out   = r_opay;
    assign o_payload_valid = r_opvld;
    assign o_position      = r_opos;
    assign o_last          = r_olast;

endmodule

@@ design/keyed_list_multimap_core.sv @@
// Flow: the back pops an item from the queue only in S_IDLE, then searches the used keys
// (one stored key per cycle) and executes the item in S_EXEC; with an empty table the
// search is skipped. A single-result item loads the result register from S_EXEC; a
// retrieve then streams its payloads from S_STREAM, one per result transfer. The back
// handles one item at a time; a two-item queue lets transfers continue meanwhile.
// Reset: synchronous, active low; empties the queue and the key table (count to zero).
// Top level of the keyed list multimap; depends on klm_pkg, klm_front, klm_back.
`timescale 1ns / 1ps

module keyed_list_multimap_core #(
    parameter int MAX_KEYS     = klm_pkg::MAX_KEYS,
    parameter int MAX_PER_KEY  = klm_pkg::MAX_PER_KEY,
    parameter int PAYLOAD_BITS = klm_pkg::PAYLOAD_BITS,
    parameter int KEY_BITS     = klm_pkg::KEY_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [KEY_BITS-1:0]                 i_node_key,
    input  logic [PAYLOAD_BITS-1:0]             i_payload_in,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [klm_pkg::STATUS_W-1:0]        o_status,
    output logic [klm_pkg::PAY_OUT_W-1:0]       o_payload_out,
    output logic                                o_payload_valid,
    output logic [klm_pkg::POS_W-1:0]           o_position,
    output logic                                o_last
);

    logic                    q_valid;
    klm_pkg::t_op            q_op;
    logic [KEY_BITS-1:0]     q_key;
    logic [PAYLOAD_BITS-1:0] q_pay;
    logic                    q_pop;
    klm_pkg::t_status        status;

    klm_front #(
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_node_key   (i_node_key),
        .i_payload_in (i_payload_in),
        .o_q_valid    (q_valid),
        .o_q_op       (q_op),
        .o_q_key      (q_key),
        .o_q_pay      (q_pay),
        .i_q_pop      (q_pop)
    );

    klm_back #(
        .MAX_KEYS     (MAX_KEYS),
        .MAX_PER_KEY  (MAX_PER_KEY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .i_q_key         (q_key),
        .i_q_pay         (q_pay),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_payload_out   (o_payload_out),
        .o_payload_valid (o_payload_valid),
        .o_position      (o_position),
        .o_last          (o_last)
    );

    assign o_status = status;

endmodule

@@ test/klm_checker.sv @@
// Result checker for the keyed list multimap: watches both channels, keeps its own
// copy of the key table, and compares every result transfer with the oldest expectation.
// Depends on klm_pkg for the operation and status codes and the table sizes.
`timescale 1ns / 1ps

module klm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_node_key,
    input  logic [31:0] i_payload_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_payload_out,
    input  logic        i_payload_valid,
    input  logic [3:0]  i_position,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import klm_pkg::*;

    typedef struct {
        t_status     status;
        logic [31:0] payload;
        logic        payload_valid;
        logic [3:0]  position;
        logic        last;
    } t_result;

    // Shadow of the key table
    int          keys_used;
    logic [15:0] key_table [MAX_KEYS];
    int          list_len  [MAX_KEYS];
    logic [31:0] list_words[MAX_KEYS][MAX_PER_KEY];

    t_result     expected_q[$];
    int          mismatches = 0;
    int          waiting    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic int find_slot(logic [15:0] key);
        for (int i = 0; i < keys_used; i++)
            if (key_table[i] == key) return i;
        return -1;
    endfunction

    function automatic t_result make_result(t_status st, logic [31:0] pay, logic pv,
                                            logic [3:0] pos, logic fin);
        t_result r;
        r.status        = st;
        r.payload       = pay;
        r.payload_valid = pv;
        r.position      = pos;
        r.last          = fin;
        return r;
    endfunction

    // Update the shadow table for one accepted item and queue what it should produce
    task automatic apply_item(logic op_bit, logic [15:0] key, logic [31:0] pay);
        int slot;
        int len;
        slot = find_slot(key);
        if (t_op'(op_bit) == OP_INSERT) begin
            if (slot >= 0) begin
                len = list_len[slot];
                if (len >= MAX_PER_KEY) begin
                    expected_q.push_back(make_result(ST_LIST_FULL, '0, 1'b0, '0, 1'b1));
                end else begin
                    list_words[slot][len] = pay;
                    list_len[slot] = len + 1;
                    expected_q.push_back(make_result(ST_OK, '0, 1'b0, '0, 1'b1));
                end
            end else if (keys_used >= MAX_KEYS) begin
                expected_q.push_back(make_result(ST_TABLE_FULL, '0, 1'b0, '0, 1'b1));
            end else begin
                key_table[keys_used]     = key;
                list_len[keys_used]      = 1;
                list_words[keys_used][0] = pay;
                keys_used++;
                expected_q.push_back(make_result(ST_OK, '0, 1'b0, '0, 1'b1));
            end
        end else if (slot < 0) begin
            expected_q.push_back(make_result(ST_NOT_FOUND, '0, 1'b0, '0, 1'b1));
        end else begin
            len = list_len[slot];
            for (int i = 0; i < len; i++)
                expected_q.push_back(make_result(ST_OK, list_words[slot][i], 1'b1,
                                                 i[3:0], (i == len - 1)));
        end
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // Compare result transfers first, then record input transfers of the same edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            keys_used = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got status %0d payload %0h",
                             $time, i_status, i_payload_out);
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("payload_out", want.payload, i_payload_out);
                    check_field("payload_valid", 32'(want.payload_valid),
                                32'(i_payload_valid));
                    check_field("position", 32'(want.position), 32'(i_position));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_item(i_func, i_node_key, i_payload_in);
        end
        waiting = expected_q.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the keyed list multimap testbench: clock, reset, item stimulus and receiver
// stalls, with the verdict taken from the result checker's failure count.
// Depends on klm_pkg, keyed_list_multimap_core and klm_checker.
`timescale 1ns / 1ps

module testbench;
    import klm_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 400;

    // Receiver behavior
    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;
    localparam int RX_HOLD  = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic [15:0] i_node_key = '0;
    logic [31:0] i_payload_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_payload_out;
    logic        o_payload_valid;
    logic [3:0]  o_position;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    logic        in_taken = 1'b0;
    int          rx_mode = RX_FREE;
    int          rx_mode_q = RX_FREE;
    int          hold_left = 0;
    bit          hold_seen = 0;
    int          gap_max = 0;
    int          burst_left = 0;
    logic [15:0] key_pool[40];

    always #5 i_clk = ~i_clk;

    keyed_list_multimap_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_node_key      (i_node_key),
        .i_payload_in    (i_payload_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_payload_out   (o_payload_out),
        .o_payload_valid (o_payload_valid),
        .o_position      (o_position),
        .o_last          (o_last)
    );

    klm_checker result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_node_key      (i_node_key),
        .i_payload_in    (i_payload_in),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_payload_out   (o_payload_out),
        .i_payload_valid (o_payload_valid),
        .i_position      (o_position),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Note input transfers and latch the receiver mode at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        rx_mode_q <= rx_mode;
    end

    // Abort a run that stops making progress
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall per mode, with one long hold-off counted here
    always @(negedge i_clk) begin
        if (rx_mode_q != RX_HOLD) begin
            hold_seen = 0;
        end else if (!hold_seen) begin
            hold_seen = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode_q)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
                default:  i_out_stall <= ($urandom_range(0, 99) < 30);
            endcase
        end
    end

    // Offer one item and hold it until the transfer; drop valid for a gap between bursts
    task automatic send_item(t_op op, logic [15:0] key, logic [31:0] pay);
        int gap;
        if (burst_left == 0 && gap_max > 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, gap_max);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid   <= 1'b1;
        i_func       <= op;
        i_node_key   <= key;
        i_payload_in <= pay;
        @(negedge i_clk);
        while (!in_taken) @(negedge i_clk);
        if (burst_left > 0) burst_left--;
    endtask

    // Mostly known keys so lists grow; a share of fresh keys for misses and a full table
    task automatic send_random(int pool_n, int retrieve_pct, int fresh_pct);
        t_op         op;
        logic [15:0] key;
        op = ($urandom_range(0, 99) < retrieve_pct) ? OP_RETRIEVE : OP_INSERT;
        if ($urandom_range(0, 99) < fresh_pct)
            key = 16'($urandom_range(0, 65535));
        else
            key = key_pool[$urandom_range(0, pool_n - 1)];
        send_item(op, key, $urandom());
    endtask

    // Pause the sender until every expected result has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 40; i++) key_pool[i] = 16'($urandom_range(0, 65535));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extreme keys and payloads, miss, list fill to capacity, full list
        send_item(OP_INSERT, 16'h0000, 32'h0000_0000);
        send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'h0000, 32'hA5A5_A5A5);
        send_item(OP_RETRIEVE, 16'h0000, 32'h0000_0000);
        send_item(OP_RETRIEVE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_RETRIEVE, 16'h1234, 32'h0000_0000);
        for (int i = 1; i < MAX_PER_KEY; i++)
            send_item(OP_INSERT, 16'hFFFF, 32'h5A00_0000 | (32'h1 << i));
        send_item(OP_INSERT, 16'hFFFF, 32'h1357_9BDF);
        send_item(OP_RETRIEVE, 16'hFFFF, 32'h0000_0000);
        drain();

        // Small key set, light stalls, bursty sender
        rx_mode = RX_LIGHT;
        gap_max = 6;
        for (int n = 0; n < 160; n++) send_random(20, 35, 10);

        // Long receiver hold-off while the sender keeps offering
        rx_mode = RX_HOLD;
        gap_max = 0;
        for (int n = 0; n < 24; n++) send_random(20, 70, 5);
        rx_mode = RX_LIGHT;
        drain();

        // Wider key set fills the table; heavy stalls and long gaps
        rx_mode = RX_HEAVY;
        gap_max = 10;
        for (int n = 0; n < 150; n++) send_random(40, 40, 15);
        drain();

        // Back-to-back traffic: no sender gaps and no receiver stalls
        rx_mode = RX_FREE;
        gap_max = 0;
        for (int n = 0; n < 120; n++) send_random(40, 50, 20);
        drain();

        repeat (100) @(negedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ keyed_list_multimap_core.f @@
design/klm_pkg.sv
design/klm_ram.sv
design/klm_front.sv
design/klm_back.sv
design/keyed_list_multimap_core.sv
test/klm_checker.sv
test/testbench.sv
